FILE: rtl/lfp_pkg.sv
// ----------------------------------------------------------------------------
// lfp_pkg
// Shared constants, codes and the CRC-8 byte update for the lidar frame parser.
// ----------------------------------------------------------------------------
package lfp_pkg;

  localparam int DEF_POINTS_PER_FRAME = 12;

  localparam logic [7:0]  HDR0      = 8'h54;   // 'T'
  localparam logic [7:0]  HDR1      = 8'h2C;   // ','
  localparam logic [7:0]  CRC_SEED  = 8'hD8;   // CRC of the two header bytes
  localparam logic [7:0]  CRC_POLY  = 8'h4D;
  localparam logic [15:0] FULL_TURN = 16'd36000;

  localparam int OUT_TDATA_W = 48;

  // parse phase codes
  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_HDR1 = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;

  // sequencer state codes
  localparam logic [2:0] S_RX   = 3'd0;
  localparam logic [2:0] S_ANG  = 3'd1;
  localparam logic [2:0] S_PREP = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_STEP = 3'd4;
  localparam logic [2:0] S_PT   = 3'd5;

  // MSB-first CRC-8, no final xor
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) c = {c[6:0], 1'b0} ^ CRC_POLY;
      else      c = {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

FILE: rtl/lidar_frame_parser_core.sv
// ----------------------------------------------------------------------------
// lidar_frame_parser_core
// Hunts for the scan packet header, stores the payload in a frame memory,
// checks the CRC-8 and replays the points with interpolated angles.
// ----------------------------------------------------------------------------
// Channel  | Dir | Width | Contents
// in_*     | in  | 8     | rx_byte, one serial byte per transfer
// out_*    | out | 48+1  | one point per transfer, tlast on the final point
//
// in_tready is high throughout reception, so bytes are taken as they arrive.
// A frame that passes the CRC check holds in_tready low while the sequencer
// makes the four angle reads, forms the angle span, does one reciprocal
// multiply for the angle step and a setup step, then reads the points
// (P = POINTS_PER_FRAME) on the single memory read port.
// out_tready low stretches the per-point loop; the output register lets the
// last point wait while new bytes are taken.
// Synchronous active-low reset; the frame memory needs no clearing.
// ----------------------------------------------------------------------------
module lidar_frame_parser_core #(
  parameter int POINTS_PER_FRAME = lfp_pkg::DEF_POINTS_PER_FRAME
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] rx_byte
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [15:0] distance, [23:16] intensity, [39:24] angle, [43:40] point_index, [47:44] zero
  output logic [lfp_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                           out_tlast   // last_point
);
  import lfp_pkg::*;

  localparam int STORE_LEN = 3 * POINTS_PER_FRAME + 8;
  localparam int ADDR_W    = $clog2(STORE_LEN);
  localparam int CNT_W     = $clog2(STORE_LEN + 1);
  localparam int PI_W      = $clog2(POINTS_PER_FRAME);
  localparam int END_POS   = 4 + 3 * POINTS_PER_FRAME;
  // divide by P-1 as multiply by ceil(2^21 / (P-1)); exact for 16-bit spans, P <= 32
  localparam int RECIP_SH  = 21;
  localparam logic [RECIP_SH:0] RECIP =
    (RECIP_SH + 1)'((2 ** RECIP_SH + POINTS_PER_FRAME - 2) / (POINTS_PER_FRAME - 1));

  logic [2:0]        state_r;
  logic [2:0]        sub_r;
  logic [1:0]        phase_r;
  logic [CNT_W-1:0]  count_r;
  logic [7:0]        crc_r;

  logic [7:0]        mem [STORE_LEN];
  logic [7:0]        rd_data_r;
  logic [ADDR_W-1:0] rd_addr;
  logic              mem_we;

  logic [15:0]       start_r, end_r, diff;
  logic [15:0]       q_r;
  logic [RECIP_SH+16:0] prod;
  logic [15:0]       step_r, ang_r;
  logic [16:0]       ang_sum;
  logic [PI_W-1:0]   i_r;
  logic [ADDR_W-1:0] base_r;
  logic [15:0]       dist_r;

  logic                   out_valid_r, out_valid_nxt, out_last_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                   slot_free, pt_load, in_xfer;

  assign in_tready  = (state_r == S_RX);
  assign in_xfer    = in_tvalid && in_tready;
  assign mem_we     = in_xfer && (phase_r == PH_DATA) && (count_r < CNT_W'(STORE_LEN));
  assign slot_free  = !out_valid_r || out_tready;
  assign pt_load    = (state_r == S_PT) && (sub_r == 3'd3) && slot_free;

  assign diff    = (start_r <= end_r) ? end_r - start_r : FULL_TURN + end_r - start_r;
  assign prod    = q_r * RECIP;
  assign ang_sum = {1'b0, ang_r} + {1'b0, step_r};

  // read address sequence
  always_comb begin
    rd_addr = '0;
    case (state_r)
      S_ANG: begin
        case (sub_r)
          3'd0:    rd_addr = ADDR_W'(2);
          3'd1:    rd_addr = ADDR_W'(3);
          3'd2:    rd_addr = ADDR_W'(END_POS);
          default: rd_addr = ADDR_W'(END_POS + 1);
        endcase
      end
      S_PT: begin
        case (sub_r)
          3'd0:    rd_addr = base_r;
          3'd1:    rd_addr = base_r + ADDR_W'(1);
          default: rd_addr = base_r + ADDR_W'(2);
        endcase
      end
      default: rd_addr = '0;
    endcase
  end

  // frame memory: writes only while receiving, reads rd_addr into rd_data_r each clock
  always_ff @(posedge clk) begin
    if (mem_we) mem[count_r[ADDR_W-1:0]] <= in_tdata;
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RX;
      sub_r   <= '0;
      phase_r <= PH_HUNT;
      count_r <= '0;
      crc_r   <= CRC_SEED;
    end else begin
      case (state_r)
        S_RX: begin
          if (in_xfer) begin
            case (phase_r)
              PH_HUNT: if (in_tdata == HDR0) phase_r <= PH_HDR1;
              PH_HDR1: begin
                if (in_tdata == HDR1) begin
                  phase_r <= PH_DATA;
                  count_r <= '0;
                  crc_r   <= CRC_SEED;
                end else if (in_tdata != HDR0) begin
                  phase_r <= PH_HUNT;
                end
              end
              PH_DATA: begin
                if (count_r < CNT_W'(STORE_LEN)) begin
                  crc_r   <= crc8_update(crc_r, in_tdata);
                  count_r <= count_r + CNT_W'(1);
                end else begin
                  phase_r <= PH_HUNT;
                  count_r <= '0;
                  crc_r   <= CRC_SEED;
                  if (crc_r == in_tdata) begin
                    state_r <= S_ANG;
                    sub_r   <= '0;
                  end
                end
              end
              default: phase_r <= PH_HUNT;
            endcase
          end
        end
        S_ANG: begin
          sub_r <= sub_r + 3'd1;
          if (sub_r == 3'd4) state_r <= S_PREP;
        end
        S_PREP: state_r <= S_DIV;
        S_DIV:  state_r <= S_STEP;
        S_STEP: begin
          state_r <= S_PT;
          sub_r   <= '0;
        end
        S_PT: begin
          if (sub_r != 3'd3) begin
            sub_r <= sub_r + 3'd1;
          end else if (slot_free) begin
            sub_r <= '0;
            if (i_r == PI_W'(POINTS_PER_FRAME - 1)) state_r <= S_RX;
          end
        end
        default: state_r <= S_RX;
      endcase
    end
  end

  // datapath: angle capture, divide by P-1, point walk
  always_ff @(posedge clk) begin
    if (state_r == S_ANG) begin
      case (sub_r)
        3'd1:    start_r[7:0]  <= rd_data_r;
        3'd2:    start_r[15:8] <= rd_data_r;
        3'd3:    end_r[7:0]    <= rd_data_r;
        3'd4:    end_r[15:8]   <= rd_data_r;
        default: ;
      endcase
    end
    if (state_r == S_PREP) begin
      q_r   <= diff;
      ang_r <= (start_r >= FULL_TURN) ? start_r - FULL_TURN : start_r;
    end
    if (state_r == S_DIV) begin
      q_r <= prod[RECIP_SH+15:RECIP_SH];
    end
    if (state_r == S_STEP) begin
      step_r <= (q_r >= FULL_TURN) ? q_r - FULL_TURN : q_r;
      i_r    <= '0;
      base_r <= ADDR_W'(4);
    end
    if (state_r == S_PT) begin
      if (sub_r == 3'd1) dist_r[7:0]  <= rd_data_r;
      if (sub_r == 3'd2) dist_r[15:8] <= rd_data_r;
    end
    if (pt_load) begin
      i_r    <= i_r + PI_W'(1);
      base_r <= base_r + ADDR_W'(3);
      ang_r  <= (ang_sum >= {1'b0, FULL_TURN}) ? 16'(ang_sum - {1'b0, FULL_TURN})
                                               : ang_sum[15:0];
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pt_load)         out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
    if (pt_load) begin
      out_data_r <= {4'b0, 4'(i_r), ang_r, rd_data_r, dist_r};
      out_last_r <= (i_r == PI_W'(POINTS_PER_FRAME - 1));
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // checks
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[39:24] < FULL_TURN)
    else $error("angle out of range");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_STEP |-> $past(state_r) == S_DIV)
    else $error("step formed without the divide");

  a_rd_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ANG || state_r == S_PT) |-> rd_addr < ADDR_W'(STORE_LEN))
    else $error("frame read out of range");

  a_last_exit: assert property (@(posedge clk) disable iff (!rst_n)
    pt_load && i_r == PI_W'(POINTS_PER_FRAME - 1) |=> state_r == S_RX && out_tlast)
    else $error("final point did not end replay");

  a_ang_acc: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PT |-> ang_r < FULL_TURN && step_r < FULL_TURN)
    else $error("angle accumulator out of range");

endmodule

FILE: test/lidar_frame_parser_core_tb.sv
// ----------------------------------------------------------------------------
// lidar_frame_parser_core_tb
// Drives scan packets byte by byte through the parser: frames with good and
// corrupted CRC, repeated and broken headers, header bytes inside the
// payload, wrapping and out-of-range angles, plus noise between frames.
// A scoreboard tracks the parser state, predicts the points of every frame
// that passes the CRC and checks each point transfer in order.
// ----------------------------------------------------------------------------
module lidar_frame_parser_core_tb;

  import lfp_pkg::*;

  localparam int P          = DEF_POINTS_PER_FRAME;
  localparam int STORE_LEN  = 3 * P + 8;             // payload bytes before the CRC
  localparam int PROC_LAT   = 8 + 4 * P;             // parser busy time per good frame without output stalls
  localparam int CYCLE_CAP  = 300000;
  localparam int RAND_BYTES = 310;
  localparam int MAX_PRINTS = 40;

  typedef struct {
    logic [15:0] distance;
    logic [7:0]  inten;
    logic [15:0] ang;
    logic [3:0]  idx;
    logic        last;
  } point_t;

  typedef enum int {FILL_RAND, FILL_ZERO, FILL_ONES, FILL_HDR} fill_kind_t;

  class point_scoreboard;
    point_t      pending_pts[$];
    logic [7:0]  crc_tab[256];
    logic [1:0]  phase;
    int unsigned nbytes;
    logic [7:0]  crc;
    logic [7:0]  store[STORE_LEN];
    int          errors;
    int          checked;
    int          frames_ok;
    int          frames_bad;

    function new();
      logic [7:0] r;
      for (int v = 0; v < 256; v++) begin
        r = v[7:0];
        repeat (8) r = r[7] ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
        crc_tab[v] = r;
      end
      phase      = PH_HUNT;
      nbytes     = 0;
      crc        = CRC_SEED;
      errors     = 0;
      checked    = 0;
      frames_ok  = 0;
      frames_bad = 0;
    endfunction

    function logic [7:0] crc_next(logic [7:0] c, logic [7:0] b);
      return crc_tab[c ^ b];
    endfunction

    task report(string msg);
      if (errors < MAX_PRINTS) $display("mismatch: %s", msg);
      errors++;
    endtask

    function int pending();
      return pending_pts.size();
    endfunction

    // expand a stored frame into its points
    function void predict_frame();
      int unsigned start_ang, stop_ang, diff, step;
      point_t      pt;
      start_ang = 32'({store[3], store[2]});
      stop_ang  = 32'({store[5 + 3 * P], store[4 + 3 * P]});
      if (start_ang <= stop_ang) diff = stop_ang - start_ang;
      else diff = (36000 + stop_ang - start_ang) & 32'hFFFF;
      step = (diff / (P - 1)) & 32'hFFFF;
      for (int i = 0; i < P; i++) begin
        pt.distance = {store[5 + 3 * i], store[4 + 3 * i]};
        pt.inten    = store[6 + 3 * i];
        pt.ang      = 16'((start_ang + step * i) % 36000);
        pt.idx      = 4'(i);
        pt.last     = (i == P - 1);
        pending_pts = {pending_pts, pt};
      end
    endfunction

    function void note_byte(logic [7:0] b);
      case (phase)
        PH_HUNT: begin
          if (b == HDR0) phase = PH_HDR1;
        end
        PH_HDR1: begin
          if (b == HDR1) begin
            phase  = PH_DATA;
            nbytes = 0;
            crc    = CRC_SEED;
          end else if (b != HDR0) begin
            phase = PH_HUNT;
          end
        end
        PH_DATA: begin
          if (nbytes < STORE_LEN) begin
            store[nbytes] = b;
            crc = crc_next(crc, b);
            nbytes++;
          end else begin
            phase  = PH_HUNT;
            nbytes = 0;
            if (crc == b) begin
              predict_frame();
              frames_ok++;
            end else begin
              frames_bad++;
            end
            crc = CRC_SEED;
          end
        end
        default: phase = PH_HUNT;
      endcase
    endfunction

    task check_point(logic [OUT_TDATA_W-1:0] d, logic last);
      point_t e;
      if (pending_pts.size() == 0) begin
        report($sformatf("point with nothing expected, tdata %h", d));
        return;
      end
      e = pending_pts.pop_front();
      checked++;
      if (d[15:0] !== e.distance)
        report($sformatf("point %0d distance %h, expected %h", e.idx, d[15:0], e.distance));
      if (d[23:16] !== e.inten)
        report($sformatf("point %0d intensity %h, expected %h", e.idx, d[23:16], e.inten));
      if (d[39:24] !== e.ang)
        report($sformatf("point %0d angle %0d, expected %0d", e.idx, d[39:24], e.ang));
      if (d[43:40] !== e.idx)
        report($sformatf("point_index %0d, expected %0d", d[43:40], e.idx));
      if (d[47:44] !== 4'h0)
        report($sformatf("point %0d pad bits %h not zero", e.idx, d[47:44]));
      if (last !== e.last)
        report($sformatf("point %0d tlast %b, expected %b", e.idx, last, e.last));
    endtask
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [7:0]             in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;

  point_scoreboard sb;
  int burst_left;
  int frame_bytes;
  int cycles;
  int rx_mode;
  int mode_left;
  int stall_left;

  lidar_frame_parser_core #(.POINTS_PER_FRAME(P)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d points outstanding", cycles, sb.pending());
      $display("FAIL lidar_frame_parser_core");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_point(out_tdata, out_tlast);
  end

  // receiver: switches between free-running, random and long-stall modes
  always @(negedge clk) begin
    if (mode_left == 0) begin
      rx_mode   = $urandom_range(0, 3);
      mode_left = $urandom_range(20, 120);
    end
    mode_left--;
    case (rx_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= ($urandom_range(0, 7) != 0);
      default: begin
        if (stall_left > 0) begin
          out_tready <= 1'b0;
          stall_left--;
        end else begin
          out_tready <= 1'b1;
          if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(5, 25);
        end
      end
    endcase
  end

  // one byte transfer; called and returns at a falling edge
  task automatic send_byte(input logic [7:0] b);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 12);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    sb.note_byte(b);
    burst_left--;
    frame_bytes++;
    @(negedge clk);
  endtask

  task automatic send_frame(input logic [15:0] start_ang, input logic [15:0] stop_ang,
                            input fill_kind_t fill, input bit bad_crc, input int hdr_reps);
    logic [7:0] payload[$];
    logic [7:0] c;
    logic [15:0] dist_w;
    logic [7:0]  inten;
    payload = {payload, 8'($urandom_range(0, 255))};
    payload = {payload, 8'($urandom_range(0, 255))};
    payload = {payload, start_ang[7:0]};
    payload = {payload, start_ang[15:8]};
    for (int i = 0; i < P; i++) begin
      case (fill)
        FILL_ZERO: begin dist_w = 16'h0000; inten = 8'h00; end
        FILL_ONES: begin dist_w = 16'hFFFF; inten = 8'hFF; end
        FILL_HDR:  begin dist_w = {HDR1, HDR0}; inten = HDR0; end
        default:   begin
          dist_w = 16'($urandom_range(0, 65535));
          inten  = 8'($urandom_range(0, 255));
        end
      endcase
      payload = {payload, dist_w[7:0]};
      payload = {payload, dist_w[15:8]};
      payload = {payload, inten};
    end
    payload = {payload, stop_ang[7:0]};
    payload = {payload, stop_ang[15:8]};
    payload = {payload, 8'($urandom_range(0, 255))};
    payload = {payload, 8'($urandom_range(0, 255))};
    c = CRC_SEED;
    foreach (payload[k]) c = sb.crc_next(c, payload[k]);
    if (bad_crc) c = c ^ (8'h01 << $urandom_range(0, 7));
    payload = {payload, c};
    repeat (hdr_reps) send_byte(HDR0);
    send_byte(HDR1);
    foreach (payload[k]) send_byte(payload[k]);
  endtask

  function automatic logic [15:0] pick_angle(input int kind);
    case (kind)
      0:       return 16'($urandom_range(0, 35999));
      1:       return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(35000, 36999));
    endcase
  endfunction

  initial begin
    int kind;
    sb          = new();
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = 8'h00;
    out_tready  = 1'b0;
    burst_left  = 0;
    frame_bytes = 0;
    cycles      = 0;
    rx_mode     = 0;
    mode_left   = 0;
    stall_left  = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: noise and a broken header, then frames covering the corner cases
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(HDR1);
    send_byte(HDR0);
    send_byte(8'h00);
    send_frame(16'd1000, 16'd12000, FILL_ZERO, 1'b0, 3);   // repeated header byte
    send_frame(16'd35000, 16'd500, FILL_ONES, 1'b0, 1);    // wrap through zero
    send_frame(16'hFFFF, 16'h0000, FILL_RAND, 1'b0, 1);    // start above end + full turn
    send_frame(16'd40000, 16'hFFFF, FILL_RAND, 1'b0, 1);   // start beyond a full turn
    send_frame(16'd0, 16'd0, FILL_HDR, 1'b0, 1);           // header bytes as payload
    send_frame(16'd100, 16'd2300, FILL_RAND, 1'b1, 1);     // corrupted CRC, dropped

    // random: mostly well-formed frames, some corrupted, some noise and broken headers
    while (frame_bytes < RAND_BYTES) begin
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        send_frame(pick_angle($urandom_range(0, 3)), pick_angle($urandom_range(0, 3)),
                   FILL_RAND, 1'b0, ($urandom_range(0, 4) == 0) ? 2 : 1);
      end else if (kind == 7) begin
        send_frame(pick_angle(1), pick_angle(1), FILL_RAND, 1'b1, 1);
      end else if (kind == 8) begin
        repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
      end else begin
        send_byte(HDR0);
        send_byte($urandom_range(0, 1) ? 8'h00 : 8'h2D);
      end
    end
    in_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (4 * PROC_LAT) @(posedge clk);

    $display("sent %0d good and %0d corrupted frames plus noise and broken headers",
             sb.frames_ok, sb.frames_bad);
    $display("checked %0d points, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS lidar_frame_parser_core");
    end else begin
      $display("FAIL lidar_frame_parser_core");
    end
    $finish;
  end

endmodule
